// ===== rtl/ntc_pkg.sv =====
// ============================================================================
// ntc_pkg
// Shared types, constants and compare functions for the neighbourhood
// tolerance compare core.
// ============================================================================
`default_nettype none

package ntc_pkg;

    // Geometry and value format
    localparam int MAX_WIDTH  = 1024;
    localparam int MAX_HEIGHT = 1024;
    localparam int VALUE_BITS = 24;

    localparam int COL_W      = $clog2(MAX_WIDTH);
    localparam int ROW_W      = $clog2(MAX_HEIGHT);
    localparam int DIM_W      = 11;                 // frame size register width
    localparam int MIN_DIM    = 3;
    localparam int TOL_W      = 23;
    localparam int CNT_W      = 21;
    localparam int LINE_DEPTH = 2 * MAX_WIDTH;      // two rows per line buffer
    localparam int LINE_AW    = $clog2(LINE_DEPTH);
    localparam int CELL_W     = 2 + VALUE_BITS;
    localparam int DIFF_W     = ((VALUE_BITS > TOL_W) ? VALUE_BITS : TOL_W) + 2;

    // APB
    localparam int APB_AW = 4;
    localparam int APB_DW = 32;

    typedef enum logic [1:0] {
        REG_TOLERANCE  = 2'd0,
        REG_INCOMPLETE = 2'd1,
        REG_WIDTH      = 2'd2,
        REG_HEIGHT     = 2'd3
    } reg_index_t;

    typedef enum logic [1:0] {
        KIND_FIN = 2'd0,
        KIND_INF = 2'd1,
        KIND_UNK = 2'd2
    } kind_t;

    // One height sample with its class
    typedef struct packed {
        kind_t                         kind;
        logic signed [VALUE_BITS-1:0]  val;
    } cell_t;

    // Cross-shaped neighbourhood around the reported pixel
    typedef struct packed {
        cell_t t_center;
        cell_t t_up;
        cell_t t_down;
        cell_t t_left;
        cell_t t_right;
        cell_t q_center;
        cell_t q_up;
        cell_t q_down;
        cell_t q_left;
        cell_t q_right;
    } win_t;

    // a - b < -tol, with unknown differences failing
    function automatic logic below_neg_tol(cell_t a, cell_t b, logic [TOL_W-1:0] tol);
        logic signed [DIFF_W-1:0] av;
        logic signed [DIFF_W-1:0] bv;
        logic signed [DIFF_W-1:0] tv;
        logic signed [DIFF_W-1:0] d;
        logic                     res;
        av = {{(DIFF_W-VALUE_BITS){a.val[VALUE_BITS-1]}}, a.val};
        bv = {{(DIFF_W-VALUE_BITS){b.val[VALUE_BITS-1]}}, b.val};
        tv = {{(DIFF_W-TOL_W){1'b0}}, tol};
        d  = av - bv + tv;
        if (a.kind == KIND_UNK || b.kind == KIND_UNK) begin
            res = 1'b0;
        end
        else if (a.kind == KIND_INF) begin
            res = 1'b0;                 // +inf minus anything finite, or inf-inf
        end
        else if (b.kind == KIND_INF) begin
            res = 1'b1;                 // finite minus +inf
        end
        else begin
            res = d[DIFF_W-1];
        end
        return res;
    endfunction

    // a - b > tol, with unknown differences failing
    function automatic logic above_tol(cell_t a, cell_t b, logic [TOL_W-1:0] tol);
        logic signed [DIFF_W-1:0] av;
        logic signed [DIFF_W-1:0] bv;
        logic signed [DIFF_W-1:0] tv;
        logic signed [DIFF_W-1:0] d;
        logic                     res;
        av = {{(DIFF_W-VALUE_BITS){a.val[VALUE_BITS-1]}}, a.val};
        bv = {{(DIFF_W-VALUE_BITS){b.val[VALUE_BITS-1]}}, b.val};
        tv = {{(DIFF_W-TOL_W){1'b0}}, tol};
        d  = av - bv - tv;
        if (a.kind == KIND_UNK || b.kind == KIND_UNK) begin
            res = 1'b0;
        end
        else if (a.kind == KIND_INF) begin
            res = (b.kind != KIND_INF);
        end
        else if (b.kind == KIND_INF) begin
            res = 1'b0;
        end
        else begin
            res = !d[DIFF_W-1] && (d != '0);
        end
        return res;
    endfunction

    function automatic logic [CNT_W-1:0] sat_inc(logic [CNT_W-1:0] v);
        return (v == {CNT_W{1'b1}}) ? v : v + CNT_W'(1);
    endfunction

endpackage

`default_nettype wire

// ===== rtl/ntc_ram.sv =====
// ============================================================================
// ntc_ram
// Generic RAM: one write port, two read ports, registered read data.
// ============================================================================
`default_nettype none

module ntc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr_a,
    input  wire logic [$clog2(DEPTH)-1:0] raddr_b,
    output logic      [WIDTH-1:0]         rdata_a,
    output logic      [WIDTH-1:0]         rdata_b
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_a_reg;
    logic [WIDTH-1:0] rdata_b_reg;

    // read returns the old contents on a same-address write
    always_ff @(posedge clk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        if (re) begin
            rdata_a_reg <= mem_reg[raddr_a];
            rdata_b_reg <= mem_reg[raddr_b];
        end
    end

    assign rdata_a = rdata_a_reg;
    assign rdata_b = rdata_b_reg;

endmodule

`default_nettype wire

// ===== rtl/ntc_flags.sv =====
// ============================================================================
// ntc_flags
// False positive / false negative decision over the cross neighbourhood.
// ============================================================================
`default_nettype none

module ntc_flags (
    input  wire ntc_pkg::win_t                 win,
    input  wire logic [ntc_pkg::TOL_W-1:0]     tolerance,
    input  wire logic                          interior,
    output logic                               false_pos,
    output logic                               false_neg
);

    logic fp_all;
    logic fn_all;

    always_comb begin
        // query at center against every truth sample
        fp_all = ntc_pkg::below_neg_tol(win.q_center, win.t_center, tolerance)
              && ntc_pkg::below_neg_tol(win.q_center, win.t_up,     tolerance)
              && ntc_pkg::below_neg_tol(win.q_center, win.t_down,   tolerance)
              && ntc_pkg::below_neg_tol(win.q_center, win.t_left,   tolerance)
              && ntc_pkg::below_neg_tol(win.q_center, win.t_right,  tolerance);
        // every query sample against truth at center
        fn_all = ntc_pkg::above_tol(win.q_center, win.t_center, tolerance)
              && ntc_pkg::above_tol(win.q_up,     win.t_center, tolerance)
              && ntc_pkg::above_tol(win.q_down,   win.t_center, tolerance)
              && ntc_pkg::above_tol(win.q_left,   win.t_center, tolerance)
              && ntc_pkg::above_tol(win.q_right,  win.t_center, tolerance);
        false_pos = interior && fp_all;
        false_neg = interior && fn_all;
    end

endmodule

`default_nettype wire

// ===== rtl/neighbourhood_tolerance_compare_core.sv =====
// ============================================================================
// neighbourhood_tolerance_compare_core
// Compares a ground-truth height raster against a query raster pixel by
// pixel over a cross neighbourhood, flags false positives / negatives and
// keeps per-frame totals.
// ============================================================================
//
//  channel   handshake            payload
//  -------   ------------------   -------------------------------------------
//  in        in_valid / in_ready  truth_value, truth_kind, query_value,
//                                 query_kind (one pixel pair, raster order)
//  out       out_valid/out_ready  pixel_valid, pixel_row, pixel_col,
//                                 false_positive, false_negative, frame_done,
//                                 fp_count, fn_count, path_count
//  cfg       APB (psel/penable)   tolerance, incomplete_truth, frame_width,
//                                 frame_height at 0x0, 0x4, 0x8, 0xC
//
//  One request per cycle sustained while out_ready keeps results moving; the
//  result is registered in the line-buffer read stage, then in the result register.
//  Throughput is set by the line buffers: two read ports and one write port
//  per buffer, touched once per pixel.
//  Reset clears position, totals, tolerance and incomplete mode, sets frame size
//  to maximum; line buffers are not cleared. in_ready drops only when both the
//  stage-1 and the result register are full and the result is not being taken.
// ============================================================================
`default_nettype none

module neighbourhood_tolerance_compare_core (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,

    // APB config port
    input  wire logic                                 psel,
    input  wire logic                                 penable,
    input  wire logic                                 pwrite,
    input  wire logic [ntc_pkg::APB_AW-1:0]           paddr,
    input  wire logic [ntc_pkg::APB_DW-1:0]           pwdata,
    output logic      [ntc_pkg::APB_DW-1:0]           prdata,
    output logic                                      pready,

    // pixel pair input
    input  wire logic                                 in_valid,
    output logic                                      in_ready,
    input  wire logic signed [ntc_pkg::VALUE_BITS-1:0] truth_value,
    input  wire logic [1:0]                           truth_kind,
    input  wire logic signed [ntc_pkg::VALUE_BITS-1:0] query_value,
    input  wire logic [1:0]                           query_kind,

    // result output
    output logic                                      out_valid,
    input  wire logic                                 out_ready,
    output logic                                      pixel_valid,
    output logic      [ntc_pkg::ROW_W-1:0]            pixel_row,
    output logic      [ntc_pkg::COL_W-1:0]            pixel_col,
    output logic                                      false_positive,
    output logic                                      false_negative,
    output logic                                      frame_done,
    output logic      [ntc_pkg::CNT_W-1:0]            fp_count,
    output logic      [ntc_pkg::CNT_W-1:0]            fn_count,
    output logic      [ntc_pkg::CNT_W-1:0]            path_count
);

    localparam int COL_W  = ntc_pkg::COL_W;
    localparam int ROW_W  = ntc_pkg::ROW_W;
    localparam int DIM_W  = ntc_pkg::DIM_W;
    localparam int TOL_W  = ntc_pkg::TOL_W;
    localparam int CNT_W  = ntc_pkg::CNT_W;
    localparam int AW     = ntc_pkg::LINE_AW;
    localparam int CELL_W = ntc_pkg::CELL_W;
    localparam int VB     = ntc_pkg::VALUE_BITS;

    // ------------------------------------------------------------------
    // Config registers
    // ------------------------------------------------------------------
    logic [TOL_W-1:0] tolerance_reg;
    logic             incomplete_reg;
    logic [DIM_W-1:0] width_reg;
    logic [DIM_W-1:0] height_reg;
    logic             cfg_write;
    ntc_pkg::reg_index_t cfg_idx;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign cfg_idx   = ntc_pkg::reg_index_t'(paddr[3:2]);

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            tolerance_reg  <= '0;
            incomplete_reg <= 1'b0;
            width_reg      <= DIM_W'(ntc_pkg::MAX_WIDTH);
            height_reg     <= DIM_W'(ntc_pkg::MAX_HEIGHT);
        end
        else if (cfg_write) begin
            case (cfg_idx)
                ntc_pkg::REG_TOLERANCE:  tolerance_reg  <= pwdata[TOL_W-1:0];
                ntc_pkg::REG_INCOMPLETE: incomplete_reg <= pwdata[0];
                ntc_pkg::REG_WIDTH:      width_reg      <= pwdata[DIM_W-1:0];
                ntc_pkg::REG_HEIGHT:     height_reg     <= pwdata[DIM_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (cfg_idx)
            ntc_pkg::REG_TOLERANCE:  prdata = ntc_pkg::APB_DW'(tolerance_reg);
            ntc_pkg::REG_INCOMPLETE: prdata = ntc_pkg::APB_DW'(incomplete_reg);
            ntc_pkg::REG_WIDTH:      prdata = ntc_pkg::APB_DW'(width_reg);
            ntc_pkg::REG_HEIGHT:     prdata = ntc_pkg::APB_DW'(height_reg);
            default:                 prdata = '0;
        endcase
    end

    // Frame size saturated to the supported range
    logic [DIM_W-1:0] w_eff;
    logic [DIM_W-1:0] h_eff;

    always_comb begin
        if (width_reg < DIM_W'(ntc_pkg::MIN_DIM)) begin
            w_eff = DIM_W'(ntc_pkg::MIN_DIM);
        end
        else if (width_reg > DIM_W'(ntc_pkg::MAX_WIDTH)) begin
            w_eff = DIM_W'(ntc_pkg::MAX_WIDTH);
        end
        else begin
            w_eff = width_reg;
        end
        if (height_reg < DIM_W'(ntc_pkg::MIN_DIM)) begin
            h_eff = DIM_W'(ntc_pkg::MIN_DIM);
        end
        else if (height_reg > DIM_W'(ntc_pkg::MAX_HEIGHT)) begin
            h_eff = DIM_W'(ntc_pkg::MAX_HEIGHT);
        end
        else begin
            h_eff = height_reg;
        end
    end

    // ------------------------------------------------------------------
    // Handshake / pipeline control
    // ------------------------------------------------------------------
    logic s1_valid_reg;
    logic out_valid_reg;
    logic s1_move;
    logic in_fire;

    assign s1_move  = s1_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !s1_valid_reg || s1_move;
    assign in_fire  = in_valid && in_ready;

    // ------------------------------------------------------------------
    // Raster position and per-request decode (accept side)
    // ------------------------------------------------------------------
    logic [ROW_W-1:0] row_reg;
    logic [COL_W-1:0] col_reg;
    logic [DIM_W-1:0] col_plus1;
    logic [DIM_W-1:0] row_plus1;
    logic             row_end;
    logic             last_px;
    logic             interior;
    logic             par;          // line-buffer half written this row

    always_comb begin
        par       = row_reg[0];
        col_plus1 = DIM_W'(col_reg) + DIM_W'(1);
        row_plus1 = DIM_W'(row_reg) + DIM_W'(1);
        row_end   = col_plus1 >= w_eff;
        last_px   = row_end && (row_plus1 >= h_eff);
        interior  = (row_reg >= ROW_W'(2)) && (DIM_W'(row_reg) < h_eff)
                 && (col_reg != '0) && (col_plus1 < w_eff);
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            row_reg <= '0;
            col_reg <= '0;
        end
        else if (in_fire) begin
            if (row_end) begin
                col_reg <= '0;
                row_reg <= last_px ? '0 : row_reg + ROW_W'(1);
            end
            else begin
                col_reg <= col_plus1[COL_W-1:0];
            end
        end
    end

    // Input class normalization
    ntc_pkg::cell_t t_cell;
    ntc_pkg::cell_t u_cell;
    logic           path_hit;

    always_comb begin
        case (truth_kind)
            2'd0: begin
                t_cell.kind = ntc_pkg::KIND_FIN;
                t_cell.val  = truth_value;
            end
            2'd1: begin
                t_cell.kind = ntc_pkg::KIND_INF;
                t_cell.val  = '0;
            end
            default: begin
                // unknown truth becomes +inf unless incomplete mode
                t_cell.kind = incomplete_reg ? ntc_pkg::KIND_UNK : ntc_pkg::KIND_INF;
                t_cell.val  = '0;
            end
        endcase
        case (query_kind)
            2'd0: begin
                u_cell.kind = ntc_pkg::KIND_FIN;
                u_cell.val  = query_value;
            end
            default: begin
                // unknown query is always +inf
                u_cell.kind = ntc_pkg::KIND_INF;
                u_cell.val  = '0;
            end
        endcase
        path_hit = ((truth_kind == 2'd0) && !truth_value[VB-1] && (truth_value != '0))
                || (truth_kind == 2'd1);
    end

    // ------------------------------------------------------------------
    // Line buffers
    // Port A: row above (same half as the write) - at column 0 it reads the
    //         first entry of the previous row instead, to prime the window.
    // Port B: previous row, one column ahead.
    // ------------------------------------------------------------------
    logic [AW-1:0]     waddr;
    logic [AW-1:0]     raddr_a;
    logic [AW-1:0]     raddr_b;
    logic [CELL_W-1:0] t_rd_a;
    logic [CELL_W-1:0] t_rd_b;
    logic [CELL_W-1:0] q_rd_a;
    logic [CELL_W-1:0] q_rd_b;

    assign waddr   = {par, col_reg};
    assign raddr_a = (col_reg == '0) ? {~par, col_reg} : {par, col_reg};
    assign raddr_b = {~par, col_plus1[COL_W-1:0]};

    ntc_ram #(
        .WIDTH (CELL_W),
        .DEPTH (ntc_pkg::LINE_DEPTH)
    ) u_truth_lines (
        .clk     (clk),
        .we      (in_fire),
        .waddr   (waddr),
        .wdata   (t_cell),
        .re      (in_fire),
        .raddr_a (raddr_a),
        .raddr_b (raddr_b),
        .rdata_a (t_rd_a),
        .rdata_b (t_rd_b)
    );

    ntc_ram #(
        .WIDTH (CELL_W),
        .DEPTH (ntc_pkg::LINE_DEPTH)
    ) u_query_lines (
        .clk     (clk),
        .we      (in_fire),
        .waddr   (waddr),
        .wdata   (u_cell),
        .re      (in_fire),
        .raddr_a (raddr_a),
        .raddr_b (raddr_b),
        .rdata_a (q_rd_a),
        .rdata_b (q_rd_b)
    );

    // ------------------------------------------------------------------
    // Stage 1: request held while line-buffer data is read
    // ------------------------------------------------------------------
    ntc_pkg::cell_t   s1_t_reg;
    ntc_pkg::cell_t   s1_q_reg;
    logic             s1_pix_valid_reg;
    logic [ROW_W-1:0] s1_row_reg;
    logic [COL_W-1:0] s1_col_reg;
    logic             s1_interior_reg;
    logic             s1_done_reg;
    logic             s1_path_reg;
    logic             s1_first_reg;

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            s1_valid_reg <= 1'b0;
        end
        else if (in_fire) begin
            s1_valid_reg <= 1'b1;
        end
        else if (s1_move) begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk) begin
        if (in_fire) begin
            s1_t_reg         <= t_cell;
            s1_q_reg         <= u_cell;
            s1_pix_valid_reg <= (row_reg != '0);
            s1_row_reg       <= (row_reg != '0) ? row_reg - ROW_W'(1) : '0;
            s1_col_reg       <= (row_reg != '0) ? col_reg : '0;
            s1_interior_reg  <= interior;
            s1_done_reg      <= last_px;
            s1_path_reg      <= path_hit;
            s1_first_reg     <= (col_reg == '0);
        end
    end

    // Sliding window over the previous row: left and center columns.
    ntc_pkg::cell_t t_left_reg;
    ntc_pkg::cell_t t_cen_reg;
    ntc_pkg::cell_t q_left_reg;
    ntc_pkg::cell_t q_cen_reg;

    always_ff @(posedge clk) begin
        if (s1_move) begin
            t_left_reg <= s1_first_reg ? ntc_pkg::cell_t'(t_rd_a) : t_cen_reg;
            q_left_reg <= s1_first_reg ? ntc_pkg::cell_t'(q_rd_a) : q_cen_reg;
            t_cen_reg  <= ntc_pkg::cell_t'(t_rd_b);
            q_cen_reg  <= ntc_pkg::cell_t'(q_rd_b);
        end
    end

    ntc_pkg::win_t win;
    logic          fp_hit;
    logic          fn_hit;

    always_comb begin
        win.t_center = t_cen_reg;
        win.t_up     = ntc_pkg::cell_t'(t_rd_a);
        win.t_down   = s1_t_reg;
        win.t_left   = t_left_reg;
        win.t_right  = ntc_pkg::cell_t'(t_rd_b);
        win.q_center = q_cen_reg;
        win.q_up     = ntc_pkg::cell_t'(q_rd_a);
        win.q_down   = s1_q_reg;
        win.q_left   = q_left_reg;
        win.q_right  = ntc_pkg::cell_t'(q_rd_b);
    end

    ntc_flags u_flags (
        .win       (win),
        .tolerance (tolerance_reg),
        .interior  (s1_interior_reg),
        .false_pos (fp_hit),
        .false_neg (fn_hit)
    );

    // ------------------------------------------------------------------
    // Frame totals and result register
    // ------------------------------------------------------------------
    logic [CNT_W-1:0] fp_total_reg;
    logic [CNT_W-1:0] fn_total_reg;
    logic [CNT_W-1:0] paths_total_reg;
    logic [CNT_W-1:0] fp_total_next;
    logic [CNT_W-1:0] fn_total_next;
    logic [CNT_W-1:0] paths_total_next;

    assign fp_total_next    = fp_hit      ? ntc_pkg::sat_inc(fp_total_reg)    : fp_total_reg;
    assign fn_total_next    = fn_hit      ? ntc_pkg::sat_inc(fn_total_reg)    : fn_total_reg;
    assign paths_total_next = s1_path_reg ? ntc_pkg::sat_inc(paths_total_reg) : paths_total_reg;

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            fp_total_reg    <= '0;
            fn_total_reg    <= '0;
            paths_total_reg <= '0;
            out_valid_reg   <= 1'b0;
        end
        else begin
            if (s1_move) begin
                // totals restart after the frame's last pixel
                fp_total_reg    <= s1_done_reg ? '0 : fp_total_next;
                fn_total_reg    <= s1_done_reg ? '0 : fn_total_next;
                paths_total_reg <= s1_done_reg ? '0 : paths_total_next;
                out_valid_reg   <= 1'b1;
            end
            else if (out_ready) begin
                out_valid_reg   <= 1'b0;
            end
        end
    end

    logic             pixel_valid_reg;
    logic [ROW_W-1:0] pixel_row_reg;
    logic [COL_W-1:0] pixel_col_reg;
    logic             false_positive_reg;
    logic             false_negative_reg;
    logic             frame_done_reg;
    logic [CNT_W-1:0] fp_count_reg;
    logic [CNT_W-1:0] fn_count_reg;
    logic [CNT_W-1:0] path_count_reg;

    always_ff @(posedge clk) begin
        if (s1_move) begin
            pixel_valid_reg    <= s1_pix_valid_reg;
            pixel_row_reg      <= s1_row_reg;
            pixel_col_reg      <= s1_col_reg;
            false_positive_reg <= fp_hit;
            false_negative_reg <= fn_hit;
            frame_done_reg     <= s1_done_reg;
            fp_count_reg       <= fp_total_next;
            fn_count_reg       <= fn_total_next;
            path_count_reg     <= paths_total_next;
        end
    end

    assign out_valid      = out_valid_reg;
    assign pixel_valid    = pixel_valid_reg;
    assign pixel_row      = pixel_row_reg;
    assign pixel_col      = pixel_col_reg;
    assign false_positive = false_positive_reg;
    assign false_negative = false_negative_reg;
    assign frame_done     = frame_done_reg;
    assign fp_count       = fp_count_reg;
    assign fn_count       = fn_count_reg;
    assign path_count     = path_count_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------

    // A pixel cannot be both below -tol and above +tol against its own truth.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> !(false_positive_reg && false_negative_reg))
    else $error("pixel flagged as both false positive and false negative");

    // While the frame-end result is pending, totals have already restarted.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && frame_done_reg) |->
            (fp_total_reg == '0 && fn_total_reg == '0 && paths_total_reg == '0))
    else $error("frame totals not cleared at frame end");

    // Back-pressure only when both pipeline registers hold a request.
    assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> (s1_valid_reg && out_valid_reg && !out_ready))
    else $error("input stalled with free pipeline space");

    // Flags only on a reported pixel.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && (false_positive_reg || false_negative_reg)) |-> pixel_valid_reg)
    else $error("flag set on a result with no reported pixel");

endmodule

`default_nettype wire
